### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the fat12 table engine modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define FAT12_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define FAT12_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/fat12_pkg.sv
// ---------------------------------------------------------------------------
// fat12_pkg
// Types, codes and constants of the fat12 cluster table engine.
// ---------------------------------------------------------------------------
package fat12_pkg;

  // operation codes
  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_RBYTE = 3'd1,
    OP_READ  = 3'd2,
    OP_NEXT  = 3'd3,
    OP_WRITE = 3'd4,
    OP_ALLOC = 3'd5
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // memory address source
  typedef enum logic [1:0] {
    MA_BYTE = 2'd0,
    MA_OFF0 = 2'd1,
    MA_OFF1 = 2'd2
  } ma_t;

  // memory write data source
  typedef enum logic [1:0] {
    WD_BVAL = 2'd0,
    WD_NEW0 = 2'd1,
    WD_NEW1 = 2'd2
  } wd_t;

  // result selection
  typedef enum logic [2:0] {
    RS_OK    = 3'd0,
    RS_RANGE = 3'd1,
    RS_BYTE  = 3'd2,
    RS_ENTRY = 3'd3,
    RS_NEXT  = 3'd4,
    RS_ALLOC = 3'd5,
    RS_FULL  = 3'd6
  } rs_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RB,
    S_ACHK,
    S_RD0,
    S_RD1,
    S_RD2,
    S_WR0,
    S_WR1,
    S_DONE
  } state_t;

  localparam logic [11:0] END_OF_CHAIN = 12'hFF8;
  localparam logic [11:0] END_MARK     = 12'hFFF;
  localparam logic [11:0] FIRST_DATA   = 12'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic clus_init;
    logic clus_inc;
    logic mem_en;
    logic mem_we;
    ma_t  mem_sel;
    wd_t  wd_sel;
    logic cap0;
    logic cap1;
    logic res_load;
    rs_t  res_sel;
    logic out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic addr_ok;
    logic entry_ok;
    logic entry_zero;
    logic out_free;
  } dp_stat_t;

endpackage

### hdl/fat12_ram.sv
// ---------------------------------------------------------------------------
// fat12_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module fat12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6144
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read or write
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### hdl/fat12_datapath.sv
// ---------------------------------------------------------------------------
// fat12_datapath
// Item registers, entry offset math, table RAM and result registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fat12_datapath #(
  parameter int CLUSTER_LIMIT = 4080,
  parameter int TABLE_BYTES   = 6144
) (
  input  logic                clk,
  input  logic                rst,
  input  fat12_pkg::dp_cmd_t  cmd,
  output fat12_pkg::dp_stat_t stat,
  input  logic [2:0]          opcode,
  input  logic [12:0]         byte_address,
  input  logic [7:0]          byte_value,
  input  logic [11:0]         cluster,
  input  logic [11:0]         entry_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [11:0]         result_value,
  output logic [1:0]          status
);

  localparam int AW = $clog2(TABLE_BYTES);

  fat12_pkg::op_t     op;
  logic [12:0]        addr;
  logic [7:0]         bval;
  logic [11:0]        clus;
  logic [11:0]        ev;
  logic [7:0]         byte0;
  logic [7:0]         byte1;
  logic [11:0]        res;
  fat12_pkg::status_t res_st;

  logic [13:0]   c3;
  logic [12:0]   off;
  logic [13:0]   off1;
  logic [15:0]   pair;
  logic [11:0]   entry;
  logic [11:0]   wval;
  logic [7:0]    new0;
  logic [7:0]    new1;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    rdata;

  // item capture and cluster counter
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op   <= fat12_pkg::op_t'(opcode);
      addr <= byte_address;
      bval <= byte_value;
      ev   <= entry_value;
    end
    if (cmd.load_item) begin
      clus <= cluster;
    end else if (cmd.clus_init) begin
      clus <= fat12_pkg::FIRST_DATA;
    end else if (cmd.clus_inc) begin
      clus <= clus + 12'd1;
    end
    if (cmd.cap0) begin
      byte0 <= rdata;
    end
    if (cmd.cap1) begin
      byte1 <= rdata;
    end
  end

  // byte offset of the entry pair: (c * 3) / 2
  assign c3   = {2'b00, clus} + {1'b0, clus, 1'b0};
  assign off  = c3[13:1];
  assign off1 = {1'b0, off} + 14'd1;

  // entry from the first byte and the byte now on the read port
  assign pair  = {rdata, byte0};
  assign entry = clus[0] ? pair[15:4] : pair[11:0];

  // merged bytes for an entry write
  assign wval = (op == fat12_pkg::OP_ALLOC) ? fat12_pkg::END_MARK : ev;
  always_comb begin
    if (clus[0]) begin
      new0 = {wval[3:0], byte0[3:0]};
      new1 = wval[11:4];
    end else begin
      new0 = wval[7:0];
      new1 = {byte1[7:4], wval[11:8]};
    end
  end

  // ram address and write data selection
  always_comb begin
    case (cmd.mem_sel)
      fat12_pkg::MA_BYTE: mem_addr = addr[AW-1:0];
      fat12_pkg::MA_OFF0: mem_addr = off[AW-1:0];
      fat12_pkg::MA_OFF1: mem_addr = off1[AW-1:0];
      default:            mem_addr = addr[AW-1:0];
    endcase
    case (cmd.wd_sel)
      fat12_pkg::WD_BVAL: mem_wdata = bval;
      fat12_pkg::WD_NEW0: mem_wdata = new0;
      fat12_pkg::WD_NEW1: mem_wdata = new1;
      default:            mem_wdata = bval;
    endcase
  end

  fat12_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_BYTES)
  ) u_ram (
    .clk   (clk),
    .en    (cmd.mem_en),
    .we    (cmd.mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rdata)
  );

  // status toward the controller
  assign stat.op         = op;
  assign stat.addr_ok    = ({1'b0, addr} < 14'(TABLE_BYTES));
  assign stat.entry_ok   = (clus < 12'(CLUSTER_LIMIT)) && (off1 < 14'(TABLE_BYTES));
  assign stat.entry_zero = (entry == 12'd0);
  assign stat.out_free   = !out_valid || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        fat12_pkg::RS_OK: begin
          res    <= 12'd0;
          res_st <= fat12_pkg::ST_OK;
        end
        fat12_pkg::RS_RANGE: begin
          res    <= 12'd0;
          res_st <= fat12_pkg::ST_RANGE;
        end
        fat12_pkg::RS_BYTE: begin
          res    <= {4'd0, rdata};
          res_st <= fat12_pkg::ST_OK;
        end
        fat12_pkg::RS_ENTRY: begin
          res    <= entry;
          res_st <= fat12_pkg::ST_OK;
        end
        fat12_pkg::RS_NEXT: begin
          if (entry >= fat12_pkg::END_OF_CHAIN) begin
            res    <= fat12_pkg::END_MARK;
            res_st <= fat12_pkg::ST_END;
          end else begin
            res    <= entry;
            res_st <= fat12_pkg::ST_OK;
          end
        end
        fat12_pkg::RS_ALLOC: begin
          res    <= clus;
          res_st <= fat12_pkg::ST_OK;
        end
        fat12_pkg::RS_FULL: begin
          res    <= 12'd0;
          res_st <= fat12_pkg::ST_FULL;
        end
        default: begin
          res    <= 12'd0;
          res_st <= fat12_pkg::ST_OK;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_value <= res;
      status       <= res_st;
    end
  end

  `FAT12_ASSERT(a_out_load_valid, clk, rst, cmd.out_load |=> out_valid, "result not shown after load")
  `FAT12_ASSERT(a_end_mark, clk, rst, (out_valid && status == fat12_pkg::ST_END) |-> (result_value == fat12_pkg::END_MARK), "end of chain without end mark")
  `FAT12_ASSERT(a_full_zero, clk, rst, (out_valid && status == fat12_pkg::ST_FULL) |-> (result_value == 12'd0), "table full with nonzero result")

endmodule

### hdl/fat12_ctrl.sv
// ---------------------------------------------------------------------------
// fat12_ctrl
// Controller state machine: sequences ram accesses per operation.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fat12_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fat12_pkg::dp_stat_t stat,
  output fat12_pkg::dp_cmd_t  cmd
);

  fat12_pkg::state_t state;
  fat12_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fat12_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // no item is taken while reset is high
  assign in_ready = (state == fat12_pkg::S_IDLE) && !rst;

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.mem_sel   = fat12_pkg::MA_BYTE;
    cmd.wd_sel    = fat12_pkg::WD_BVAL;
    cmd.res_sel   = fat12_pkg::RS_OK;
    case (state)
      fat12_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = fat12_pkg::S_DECODE;
        end
      end
      fat12_pkg::S_DECODE: begin
        case (stat.op)
          fat12_pkg::OP_LOAD: begin
            cmd.res_load = 1'b1;
            if (stat.addr_ok) begin
              cmd.mem_en  = 1'b1;
              cmd.mem_we  = 1'b1;
              cmd.res_sel = fat12_pkg::RS_OK;
            end else begin
              cmd.res_sel = fat12_pkg::RS_RANGE;
            end
            state_next = fat12_pkg::S_DONE;
          end
          fat12_pkg::OP_RBYTE: begin
            if (stat.addr_ok) begin
              cmd.mem_en = 1'b1;
              state_next = fat12_pkg::S_RB;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = fat12_pkg::RS_RANGE;
              state_next   = fat12_pkg::S_DONE;
            end
          end
          fat12_pkg::OP_READ, fat12_pkg::OP_NEXT, fat12_pkg::OP_WRITE: begin
            if (stat.entry_ok) begin
              state_next = fat12_pkg::S_RD0;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = fat12_pkg::RS_RANGE;
              state_next   = fat12_pkg::S_DONE;
            end
          end
          fat12_pkg::OP_ALLOC: begin
            cmd.clus_init = 1'b1;
            state_next    = fat12_pkg::S_ACHK;
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = fat12_pkg::RS_OK;
            state_next   = fat12_pkg::S_DONE;
          end
        endcase
      end
      fat12_pkg::S_RB: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = fat12_pkg::RS_BYTE;
        state_next   = fat12_pkg::S_DONE;
      end
      // allocate scan: read the next cluster if it fits, stop as full at the first that does not
      fat12_pkg::S_ACHK: begin
        if (stat.entry_ok) begin
          state_next = fat12_pkg::S_RD0;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = fat12_pkg::RS_FULL;
          state_next   = fat12_pkg::S_DONE;
        end
      end
      fat12_pkg::S_RD0: begin
        cmd.mem_en  = 1'b1;
        cmd.mem_sel = fat12_pkg::MA_OFF0;
        state_next  = fat12_pkg::S_RD1;
      end
      fat12_pkg::S_RD1: begin
        cmd.mem_en  = 1'b1;
        cmd.mem_sel = fat12_pkg::MA_OFF1;
        cmd.cap0    = 1'b1;
        state_next  = fat12_pkg::S_RD2;
      end
      // second byte on the read port, entry is complete
      fat12_pkg::S_RD2: begin
        cmd.cap1 = 1'b1;
        case (stat.op)
          fat12_pkg::OP_READ: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = fat12_pkg::RS_ENTRY;
            state_next   = fat12_pkg::S_DONE;
          end
          fat12_pkg::OP_NEXT: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = fat12_pkg::RS_NEXT;
            state_next   = fat12_pkg::S_DONE;
          end
          fat12_pkg::OP_ALLOC: begin
            if (stat.entry_zero) begin
              state_next = fat12_pkg::S_WR0;
            end else begin
              cmd.clus_inc = 1'b1;
              state_next   = fat12_pkg::S_ACHK;
            end
          end
          default: begin
            state_next = fat12_pkg::S_WR0;
          end
        endcase
      end
      fat12_pkg::S_WR0: begin
        cmd.mem_en  = 1'b1;
        cmd.mem_we  = 1'b1;
        cmd.mem_sel = fat12_pkg::MA_OFF0;
        cmd.wd_sel  = fat12_pkg::WD_NEW0;
        state_next  = fat12_pkg::S_WR1;
      end
      fat12_pkg::S_WR1: begin
        cmd.mem_en   = 1'b1;
        cmd.mem_we   = 1'b1;
        cmd.mem_sel  = fat12_pkg::MA_OFF1;
        cmd.wd_sel   = fat12_pkg::WD_NEW1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = (stat.op == fat12_pkg::OP_ALLOC) ? fat12_pkg::RS_ALLOC
                                                         : fat12_pkg::RS_OK;
        state_next   = fat12_pkg::S_DONE;
      end
      // hand the result to the output register once it is free
      fat12_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = fat12_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fat12_pkg::S_IDLE;
      end
    endcase
  end

  `FAT12_ASSERT(a_accept_decode, clk, rst, (in_valid && in_ready) |=> (state == fat12_pkg::S_DECODE), "accepted item not decoded")
  `FAT12_ASSERT(a_write_states, clk, rst, cmd.mem_we |-> ((state == fat12_pkg::S_DECODE && stat.op == fat12_pkg::OP_LOAD) || state == fat12_pkg::S_WR0 || state == fat12_pkg::S_WR1), "ram write outside a write step")
  `FAT12_ASSERT(a_out_only_done, clk, rst, cmd.out_load |=> (state == fat12_pkg::S_IDLE), "result loaded without return to idle")

endmodule

### hdl/fat12_cluster_table_engine.sv
// ---------------------------------------------------------------------------
// fat12_cluster_table_engine
// FAT12 allocation table held in a linear byte RAM, with byte load/read,
// entry read, chain follow, entry write and lowest-free allocation.
// ---------------------------------------------------------------------------
//  channel  | signals                                           | dir
//  ---------+---------------------------------------------------+-----
//  input    | in_valid, in_ready, opcode, byte_address,         | in
//           | byte_value, cluster, entry_value                  |
//  output   | out_valid, out_ready, result_value, status        | out
//
//  one item at a time; in_ready is high only while the controller is idle
//  load byte, out-of-range and unused ops set the result in decode; read byte
//  reads the ram once; read entry / next cluster read the two entry bytes;
//  write entry writes both back; allocate scans up from cluster 2, marks the
//  first free entry as end or reports full; two reads per entry, one ram port
//  a waiting result holds the controller in its last step until taken
//  reset (rst, synchronous) clears control only; the table is undefined
//  until loaded
// ---------------------------------------------------------------------------
module fat12_cluster_table_engine #(
  parameter int CLUSTER_LIMIT = 4080,
  parameter int TABLE_BYTES   = 6144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [12:0] byte_address,
  input  logic [7:0]  byte_value,
  input  logic [11:0] cluster,
  input  logic [11:0] entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] result_value,
  output logic [1:0]  status
);

  fat12_pkg::dp_cmd_t  cmd;
  fat12_pkg::dp_stat_t stat;

  // controller
  fat12_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath with table ram
  fat12_datapath #(
    .CLUSTER_LIMIT (CLUSTER_LIMIT),
    .TABLE_BYTES   (TABLE_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .cluster      (cluster),
    .entry_value  (entry_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status)
  );

endmodule
